@@ hdl/scpc_pkg.sv @@
// Shared types, constants and character helpers for the serial command pin controller.
// No dependencies.
package scpc_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH      = 2;
    localparam int PIN_BITS         = 6;
    localparam int LATCH_BITS       = 7;
    localparam int POS_BITS         = 5;

    localparam logic [7:0]  NL         = 8'h0A;
    localparam logic [7:0]  PIN_MASK   = 8'h3F;
    localparam logic [3:0]  NIB_MASK   = 4'hF;
    localparam logic [15:0] NUM_MAX    = 16'hFFFF;
    localparam logic [15:0] MAX_PIN_NO = 16'd6;
    localparam logic [6:0]  NO_REPORT  = 7'd64;

    localparam int GREET_LEN = 20;
    localparam int ERR_LEN   = 6;
    localparam int HEX_LEN   = 5;
    localparam logic [8*GREET_LEN-1:0] GREETING = "Happy happy joy joy\n";
    localparam logic [8*ERR_LEN-1:0]   ERRMSG   = "ERROR\n";

    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_LINE,
        JOB_TICK
    } job_kind_t;

    typedef struct packed {
        job_kind_t              kind;
        logic [7:0]             data;
        logic [PIN_BITS-1:0]    pins;
    } job_t;

    typedef enum logic [1:0] {
        MSG_NONE,
        MSG_GREET,
        MSG_ERR,
        MSG_HEX
    } msg_kind_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= "a" && c <= "z")
            return c - 8'h20;
        return c;
    endfunction

    // 16 means not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 5'(c - "0");
        if (c >= "a" && c <= "f")
            return 5'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F")
            return 5'(c - "A" + 8'd10);
        return 5'd16;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'(v) + "0";
        return 8'(v) - 8'd10 + "A";
    endfunction

    function automatic logic [POS_BITS-1:0] msg_len(input msg_kind_t m);
        case (m)
            MSG_GREET: return POS_BITS'(GREET_LEN);
            MSG_ERR:   return POS_BITS'(ERR_LEN);
            MSG_HEX:   return POS_BITS'(HEX_LEN);
            default:   return '0;
        endcase
    endfunction

    function automatic logic [7:0] msg_char(input msg_kind_t m,
                                            input logic [POS_BITS-1:0] idx,
                                            input logic [PIN_BITS-1:0] p);
        logic [7:0] pw;
        pw = 8'(p) & PIN_MASK;
        case (m)
            MSG_GREET: return GREETING[8*(GREET_LEN-1-int'(idx)) +: 8];
            MSG_ERR:   return ERRMSG[8*(ERR_LEN-1-int'(idx)) +: 8];
            MSG_HEX:
            begin
                case (idx)
                    5'd0:    return "0";
                    5'd1:    return "x";
                    5'd2:    return hex_char(pw[7:4]);
                    5'd3:    return hex_char(pw[3:0] & NIB_MASK);
                    default: return NL;
                endcase
            end
            default:   return NL;
        endcase
    endfunction

endpackage

@@ hdl/scpc_if.sv @@
// Handshake channels for items in and transmit bytes out.
// Depends on scpc_pkg.
interface scpc_in_if import scpc_pkg::*;;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [7:0]          rx_byte;
    logic [PIN_BITS-1:0] in_pins;
    modport source (output valid, cmd, rx_byte, in_pins, input ready);
    modport sink   (input valid, cmd, rx_byte, in_pins, output ready);
endinterface

interface scpc_out_if import scpc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [7:0]            tx_byte;
    logic                  last;
    logic [LATCH_BITS-1:0] out_pins;
    modport source (output valid, tx_byte, last, out_pins, input ready);
    modport sink   (input valid, tx_byte, last, out_pins, output ready);
endinterface

@@ hdl/scpc_queue.sv @@
// Short job queue between the front and back parts.
// Depends on scpc_pkg.
module scpc_queue import scpc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic avail,
    output job_t pop_job
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_reg;
    logic [PW-1:0]   rd_reg;
    logic [PW:0]     count_reg;

    assign full    = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign avail   = (count_reg != '0);
    assign pop_job = entry_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end
endmodule

@@ hdl/scpc_front.sv @@
// Front part: accepts items and classifies them into jobs for the queue.
// Depends on scpc_pkg and scpc_if.
module scpc_front import scpc_pkg::*;
(
    scpc_in_if.sink items,
    input  logic    full,
    output logic    push,
    output job_t    push_job
);
    assign items.ready = !full;
    assign push        = items.valid && !full;

    always_comb
    begin
        push_job.data = items.rx_byte;
        push_job.pins = items.in_pins;
        if (items.cmd)
            push_job.kind = JOB_TICK;
        else if (items.rx_byte == NL)
            push_job.kind = JOB_LINE;
        else
            push_job.kind = JOB_BYTE;
    end
endmodule

@@ hdl/scpc_back.sv @@
// Back part: line store, command scan and decode, pin latch, transmit byte sequencer.
// Depends on scpc_pkg and scpc_if.
module scpc_back import scpc_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      avail,
    input  job_t      pop_job,
    output logic      pop,
    scpc_out_if.source results
);
    localparam int AW = $clog2(BUFFER_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        P_SKIP,
        P_DIG,
        P_DONE
    } parse_t;

    logic [7:0]            line_mem [BUFFER_DEPTH];
    logic [7:0]            mem_q_reg;

    state_t                state_reg;
    logic [AW-1:0]         wp_reg;
    logic [AW-1:0]         le_reg;
    logic [LATCH_BITS-1:0] latch_reg;
    logic [6:0]            rep_reg;
    logic [AW-1:0]         ptr_reg;
    logic [AW-1:0]         di_reg;
    logic                  dv_reg;
    logic [7:0]            hb_reg [5];
    parse_t                pa_reg;
    parse_t                pb_reg;
    logic [15:0]           xa_reg;
    logic [15:0]           xb_reg;
    msg_kind_t             msg_reg;
    logic                  echo_en_reg;
    logic [7:0]            echo_reg;
    logic [PIN_BITS-1:0]   pins_reg;
    logic [POS_BITS-1:0]   pos_reg;

    logic                  out_valid_reg;
    logic [7:0]            tx_reg;
    logic                  last_reg;
    logic [LATCH_BITS-1:0] opins_reg;

    logic                  we;
    logic [4:0]            hv;
    logic                  is_hex;
    logic [19:0]           xa_w;
    logic [19:0]           xb_w;
    logic                  is_test;
    logic                  is_set;
    logic                  is_clear;
    logic                  is_read;
    logic [15:0]           num;
    logic [LATCH_BITS-1:0] bitmask;
    logic                  slot_free;
    logic [POS_BITS-1:0]   total;
    logic [7:0]            next_char;

    assign pop = (state_reg == ST_IDLE) && avail;
    assign we  = pop && (pop_job.kind == JOB_BYTE) && (wp_reg != AW'(BUFFER_DEPTH-1));

    always_ff @(posedge clk)
    begin
        if (we)
            line_mem[wp_reg] <= pop_job.data;
        mem_q_reg <= line_mem[ptr_reg];
    end

    assign hv     = hex_val(mem_q_reg);
    assign is_hex = !hv[4];
    assign xa_w   = {xa_reg, 4'b0} + 20'(hv[3:0]);
    assign xb_w   = {xb_reg, 4'b0} + 20'(hv[3:0]);

    always_comb
    begin
        is_test  = (le_reg >= AW'(4)) && to_upper(hb_reg[0]) == "T"
                   && to_upper(hb_reg[1]) == "E" && to_upper(hb_reg[2]) == "S"
                   && to_upper(hb_reg[3]) == "T";
        is_set   = (le_reg >= AW'(3)) && to_upper(hb_reg[0]) == "S"
                   && to_upper(hb_reg[1]) == "E" && to_upper(hb_reg[2]) == "T";
        is_clear = (le_reg >= AW'(5)) && to_upper(hb_reg[0]) == "C"
                   && to_upper(hb_reg[1]) == "L" && to_upper(hb_reg[2]) == "E"
                   && to_upper(hb_reg[3]) == "A" && to_upper(hb_reg[4]) == "R";
        is_read  = (le_reg >= AW'(4)) && to_upper(hb_reg[0]) == "R"
                   && to_upper(hb_reg[1]) == "E" && to_upper(hb_reg[2]) == "A"
                   && to_upper(hb_reg[3]) == "D";
        num      = is_set ? xa_reg : xb_reg;
        bitmask  = LATCH_BITS'(1) << num[2:0];
    end

    assign slot_free = !out_valid_reg || results.ready;
    assign total     = msg_len(msg_reg) + POS_BITS'(echo_en_reg);
    assign next_char = (echo_en_reg && pos_reg == '0) ? echo_reg
                     : msg_char(msg_reg, pos_reg - POS_BITS'(echo_en_reg), pins_reg);

    assign results.valid    = out_valid_reg;
    assign results.tx_byte  = tx_reg;
    assign results.last     = last_reg;
    assign results.out_pins = opins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            le_reg        <= '0;
            latch_reg     <= '0;
            rep_reg       <= NO_REPORT;
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            dv_reg        <= 1'b0;
        end
        else
        begin
            if (results.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (avail)
                    begin
                        pins_reg <= pop_job.pins;
                        pos_reg  <= '0;
                        case (pop_job.kind)
                            JOB_BYTE:
                            begin
                                echo_en_reg <= 1'b1;
                                echo_reg    <= pop_job.data;
                                msg_reg     <= MSG_NONE;
                                if (we)
                                begin
                                    wp_reg <= wp_reg + 1'b1;
                                    le_reg <= wp_reg + 1'b1;
                                end
                                state_reg <= ST_EMIT;
                            end
                            JOB_LINE:
                            begin
                                wp_reg  <= '0;
                                ptr_reg <= '0;
                                dv_reg  <= 1'b0;
                                pa_reg  <= P_SKIP;
                                pb_reg  <= P_SKIP;
                                xa_reg  <= '0;
                                xb_reg  <= '0;
                                state_reg <= (le_reg == '0) ? ST_DECIDE : ST_SCAN;
                            end
                            default:
                            begin
                                if ({1'b0, pop_job.pins} != rep_reg)
                                begin
                                    rep_reg     <= {1'b0, pop_job.pins};
                                    echo_en_reg <= 1'b0;
                                    msg_reg     <= MSG_HEX;
                                    state_reg   <= ST_EMIT;
                                end
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    di_reg  <= ptr_reg;
                    dv_reg  <= 1'b1;
                    if (dv_reg)
                    begin
                        if (di_reg < AW'(5))
                            hb_reg[di_reg[2:0]] <= mem_q_reg;
                        if (di_reg >= AW'(3))
                        begin
                            case (pa_reg)
                                P_SKIP:
                                begin
                                    if (is_hex)
                                    begin
                                        pa_reg <= P_DIG;
                                        xa_reg <= 16'(hv[3:0]);
                                    end
                                end
                                P_DIG:
                                begin
                                    if (is_hex)
                                        xa_reg <= (xa_w > 20'(NUM_MAX)) ? NUM_MAX : xa_w[15:0];
                                    else
                                        pa_reg <= P_DONE;
                                end
                                default: ;
                            endcase
                        end
                        if (di_reg >= AW'(5))
                        begin
                            case (pb_reg)
                                P_SKIP:
                                begin
                                    if (is_hex)
                                    begin
                                        pb_reg <= P_DIG;
                                        xb_reg <= 16'(hv[3:0]);
                                    end
                                end
                                P_DIG:
                                begin
                                    if (is_hex)
                                        xb_reg <= (xb_w > 20'(NUM_MAX)) ? NUM_MAX : xb_w[15:0];
                                    else
                                        pb_reg <= P_DONE;
                                end
                                default: ;
                            endcase
                        end
                        if (di_reg == le_reg - 1'b1)
                            state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    echo_en_reg <= 1'b1;
                    echo_reg    <= NL;
                    msg_reg     <= MSG_NONE;
                    if (is_test)
                        msg_reg <= MSG_GREET;
                    else if (is_set || is_clear)
                    begin
                        if (num <= MAX_PIN_NO)
                            latch_reg <= is_set ? (latch_reg | bitmask)
                                                : (latch_reg & ~bitmask);
                        else
                            msg_reg <= MSG_ERR;
                    end
                    else if (is_read)
                    begin
                        msg_reg <= MSG_HEX;
                        rep_reg <= {1'b0, pins_reg};
                    end
                    else
                        msg_reg <= MSG_ERR;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        tx_reg        <= next_char;
                        opins_reg     <= latch_reg;
                        last_reg      <= (pos_reg == total - 1'b1);
                        pos_reg       <= pos_reg + 1'b1;
                        if (pos_reg == total - 1'b1)
                            state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ hdl/serial_command_pin_controller.sv @@
// Top level of the serial command pin controller: front, job queue, back.
// Depends on scpc_pkg, scpc_if, scpc_front, scpc_queue, scpc_back.
//
//  channel  dir  payload                       beat
//  items    in   cmd, rx_byte, in_pins         one received byte or poll tick
//  results  out  tx_byte, last, out_pins       one transmit byte
//
// A plain byte is echoed; a poll tick is reported only if its pins differ from the last report.
// A newline first scans the line through the single line store read port, then
// sends one transmitted byte per cycle while results are ready (up to 21).
// Items queue two deep while the back part works; results stall on ready.
// Reset clears pointers, latch and report state; the line store is not cleared.
module serial_command_pin_controller import scpc_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    scpc_in_if.sink     items,
    scpc_out_if.source  results
);
    logic push;
    job_t push_job;
    logic full;
    logic pop;
    logic avail;
    job_t pop_job;

    scpc_front u_front (
        .items    (items),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    scpc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .avail    (avail),
        .pop_job  (pop_job)
    );

    scpc_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .avail    (avail),
        .pop_job  (pop_job),
        .pop      (pop),
        .results  (results)
    );
endmodule

@@ tb/sv/serial_command_pin_controller_test.sv @@
// Testbench for the serial command pin controller: directed and random items,
// results checked against a behavioural predictor held in a scoreboard class.
// Depends on scpc_pkg, scpc_if and the serial_command_pin_controller RTL.
module serial_command_pin_controller_test;
    import scpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] tx_byte;
        logic       last;
        logic [6:0] out_pins;
    } tx_beat_t;

    class pin_console_board;
        logic [7:0] line_buf [256];
        int         wr_pos;
        int         line_len;
        logic [6:0] shown_pins;
        logic [6:0] latch;
        tx_beat_t   pending [$];
        logic [7:0] step_bytes [$];
        int         errors;

        function void clear();
            wr_pos = 0;
            line_len = 0;
            shown_pins = NO_REPORT;
            latch = '0;
            pending.delete();
            errors = 0;
        endfunction

        function logic [7:0] upcase(logic [7:0] c);
            if (c >= "a" && c <= "z")
                return c - 8'h20;
            return c;
        endfunction

        function int digit_of(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return c - "0";
            if (c >= "a" && c <= "f")
                return c - "a" + 10;
            if (c >= "A" && c <= "F")
                return c - "A" + 10;
            return 16;
        endfunction

        function logic [7:0] nibble_char(logic [3:0] v);
            return v < 10 ? 8'(v) + "0" : 8'(v) - 8'd10 + "A";
        endfunction

        function bit starts_with(string w);
            if (w.len() > line_len)
                return 0;
            for (int i = 0; i < w.len(); i++)
                if (upcase(line_buf[i]) != w[i])
                    return 0;
            return 1;
        endfunction

        function int first_number(int i);
            int x;
            x = 0;
            while (i < line_len && digit_of(line_buf[i]) >= 16)
                i++;
            while (i < line_len && digit_of(line_buf[i]) < 16)
            begin
                x = x * 16 + digit_of(line_buf[i]);
                if (x > 'hFFFF)
                    x = 'hFFFF;
                i++;
            end
            return x;
        endfunction

        function void say(string s);
            for (int i = 0; i < s.len(); i++)
                step_bytes.push_back(s[i]);
        endfunction

        function void show_pins(logic [5:0] p);
            shown_pins = {1'b0, p};
            step_bytes.push_back("0");
            step_bytes.push_back("x");
            step_bytes.push_back(nibble_char({2'b00, p[5:4]}));
            step_bytes.push_back(nibble_char(p[3:0]));
            step_bytes.push_back(NL);
        endfunction

        function void note_item(logic cmd, logic [7:0] b, logic [5:0] p);
            int n;
            tx_beat_t t;
            step_bytes.delete();
            if (cmd)
            begin
                if ({1'b0, p} != shown_pins)
                    show_pins(p);
            end
            else if (b == NL)
            begin
                step_bytes.push_back(NL);
                if (starts_with("TEST"))
                    say("Happy happy joy joy\n");
                else if (starts_with("SET"))
                begin
                    n = first_number(3);
                    if (n <= 6) latch = latch | (7'd1 << n);
                    else say("ERROR\n");
                end
                else if (starts_with("CLEAR"))
                begin
                    n = first_number(5);
                    if (n <= 6) latch = latch & ~(7'd1 << n);
                    else say("ERROR\n");
                end
                else if (starts_with("READ"))
                    show_pins(p);
                else
                    say("ERROR\n");
                wr_pos = 0;
            end
            else
            begin
                step_bytes.push_back(b);
                if (wr_pos < 255)
                begin
                    line_buf[wr_pos] = b;
                    wr_pos++;
                    line_len = wr_pos;
                end
            end
            foreach (step_bytes[k])
            begin
                t.tx_byte = step_bytes[k];
                t.last = (k == step_bytes.size() - 1);
                t.out_pins = latch;
                pending.push_back(t);
            end
        endfunction

        function void check_beat(logic [7:0] b, logic l, logic [6:0] o);
            tx_beat_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected beat tx_byte=%h last=%b out_pins=%h",
                         $time, b, l, o);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (b !== e.tx_byte || l !== e.last || o !== e.out_pins)
            begin
                $display("%0t: expected tx_byte=%h last=%b out_pins=%h, got %h %b %h",
                         $time, e.tx_byte, e.last, e.out_pins, b, l, o);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    scpc_in_if  items ();
    scpc_out_if results ();
    pin_console_board board;

    serial_command_pin_controller u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #40ms;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && results.valid && results.ready)
            board.check_beat(results.tx_byte, results.last, results.out_pins);

    // receiver stalls
    initial
    begin
        int w;
        results.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            repeat (w) @(posedge clk);
            results.ready <= 1'b1;
            @(posedge clk iff results.valid);
            results.ready <= 1'b0;
        end
    end

    // valid stays up after a beat until the next gap or an explicit drop
    task automatic send_item(logic cmd, logic [7:0] b, logic [5:0] p, bit no_gap = 0);
        int w;
        w = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (w > 0)
        begin
            items.valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        items.valid   <= 1'b1;
        items.cmd     <= cmd;
        items.rx_byte <= b;
        items.in_pins <= p;
        @(posedge clk iff items.ready);
        board.note_item(cmd, b, p);
    endtask

    task automatic send_line(string s, bit newline = 1);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, s[i], 6'($urandom));
        if (newline)
            send_item(1'b0, NL, 6'($urandom));
    endtask

    function automatic string rand_line();
        string heads [8];
        string s;
        int k;
        heads = '{"set ", "SET", "clear", "Clear ", "test", "READ", "rEaD x", "bogus"};
        s = heads[$urandom_range(0, 7)];
        k = $urandom_range(0, 3);
        if (k == 0)
            s = {s, $sformatf("%0d", $urandom_range(0, 7))};
        else if (k == 1)
            s = {s, $sformatf(" z%0h", $urandom_range(0, 'h1FFFF))};
        else if (k == 2)
            s = {s, "-q", $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    initial
    begin
        board = new();
        board.clear();
        rst_n = 1'b0;
        items.valid = 1'b0;
        items.cmd = 1'b0;
        items.rx_byte = '0;
        items.in_pins = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(1'b1, 8'hFF, 6'h00);
        send_item(1'b1, 8'h00, 6'h00);
        send_item(1'b1, 8'hA5, 6'h3F);
        send_line("TesT");
        send_item(1'b0, NL, 6'h15);
        send_line("set 6");
        send_line("SET");
        send_line("set 7");
        send_line("set 1ffff");
        send_line("clear 6");
        send_line("read");
        send_line("xyz");
        send_item(1'b0, 8'h00, 6'h2A);
        send_item(1'b0, NL, 6'h2A);

        items.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);

        // overfill the line store, then a short line over it
        send_item(1'b0, "s", 6'h01, 1);
        send_item(1'b0, "e", 6'h01, 1);
        send_item(1'b0, "t", 6'h01, 1);
        for (int i = 0; i < 258; i++)
            send_item(1'b0, (i == 0) ? "3" : "g", 6'($urandom), 1);
        send_item(1'b0, NL, 6'h00);
        send_line("CLEAR 3");

        for (int n = 0; n < 30; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1: send_item(1'b1, 8'($urandom), 6'($urandom_range(0, 3)));
                2:    send_item(1'b0, 8'($urandom), 6'($urandom));
                3:    send_item(1'b0, NL, 6'($urandom));
                default: send_line(rand_line());
            endcase
        end

        items.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

@@ serial_command_pin_controller.f @@
hdl/scpc_pkg.sv
hdl/scpc_if.sv
hdl/scpc_queue.sv
hdl/scpc_front.sv
hdl/scpc_back.sv
hdl/serial_command_pin_controller.sv
tb/sv/serial_command_pin_controller_test.sv
